[design/hons_pkg.sv]
// Shared constants, types and helpers for the hashed owner node select block.
`timescale 1ns / 1ps
`default_nettype none
package hons_pkg;

   localparam int unsigned MAX_NODES_DEF = 256;

   localparam int unsigned CNT_W  = 9;
   localparam int unsigned IDX_W  = 8;
   localparam int unsigned KEY_W  = 64;
   localparam int unsigned DESC_W = 32;
   localparam int unsigned ADDR_W = 4;
   localparam int unsigned DATA_W = 32;

   localparam logic [KEY_W-1:0] MIX_MUL_A = 64'hbf58476d1ce4e5b9;
   localparam logic [KEY_W-1:0] MIX_MUL_B = 64'h94d049bb133111eb;
   localparam int unsigned MIX_SHIFT_A = 30;
   localparam int unsigned MIX_SHIFT_B = 27;
   localparam int unsigned MIX_SHIFT_C = 31;
   localparam int unsigned MIX_STAGES  = 5;

   localparam int unsigned DIGIT_BITS = 8;
   localparam int unsigned DIV_STAGES = KEY_W / DIGIT_BITS;

   localparam logic [1:0] REG_NODE_COUNT = 2'd0;
   localparam logic [1:0] REG_RINGS_EN   = 2'd1;
   localparam logic [1:0] REG_MULTI_EN   = 2'd2;

   localparam logic [CNT_W-1:0] NODE_COUNT_RST = 9'd1;

   typedef struct packed {
      logic             take_fb;
      logic [IDX_W-1:0] fb;
   } side_type;

   // Fold the upper bits down: v xor (v shifted right by sh)
   function automatic logic [KEY_W-1:0] xorshift(input logic [KEY_W-1:0] v,
                                                 input int unsigned sh);
      xorshift = v ^ (v >> sh);
   endfunction

endpackage
`default_nettype wire

[design/hons_mix.sv]
// Five-stage splitmix64 finalizer built from 32-bit partial products.
`timescale 1ns / 1ps
`default_nettype none
module hons_mix (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [hons_pkg::KEY_W-1:0] value,
   output logic      [hons_pkg::KEY_W-1:0] hash
);
   import hons_pkg::*;

   logic [KEY_W-1:0] x_ff, x_in;
   logic [KEY_W-1:0] a_ll_ff, a_ll_in;
   logic [31:0]      a_lh_ff, a_lh_in, a_hl_ff, a_hl_in;
   logic [KEY_W-1:0] z_ff, z_in;
   logic [KEY_W-1:0] b_ll_ff, b_ll_in;
   logic [31:0]      b_lh_ff, b_lh_in, b_hl_ff, b_hl_in;
   logic [KEY_W-1:0] h_ff, h_in;

   always_comb begin
      x_in    = xorshift(value, MIX_SHIFT_A);
      a_ll_in = {32'd0, x_ff[31:0]} * {32'd0, MIX_MUL_A[31:0]};
      a_lh_in = x_ff[31:0] * MIX_MUL_A[63:32];
      a_hl_in = x_ff[63:32] * MIX_MUL_A[31:0];
      z_in    = xorshift(a_ll_ff + {a_lh_ff + a_hl_ff, 32'd0}, MIX_SHIFT_B);
      b_ll_in = {32'd0, z_ff[31:0]} * {32'd0, MIX_MUL_B[31:0]};
      b_lh_in = z_ff[31:0] * MIX_MUL_B[63:32];
      b_hl_in = z_ff[63:32] * MIX_MUL_B[31:0];
      h_in    = xorshift(b_ll_ff + {b_lh_ff + b_hl_ff, 32'd0}, MIX_SHIFT_C);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         a_ll_ff <= a_ll_in;
         a_lh_ff <= a_lh_in;
         a_hl_ff <= a_hl_in;
         z_ff    <= z_in;
         b_ll_ff <= b_ll_in;
         b_lh_ff <= b_lh_in;
         b_hl_ff <= b_hl_in;
         h_ff    <= h_in;
      end
   end

   assign hash = h_ff;
endmodule
`default_nettype wire

[design/hons_div_step.sv]
// One stage of the pipelined remainder: eight restoring steps on one dividend byte.
`timescale 1ns / 1ps
`default_nettype none
module hons_div_step (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic [hons_pkg::KEY_W-1:0] dvd_in,
   input  wire logic [hons_pkg::CNT_W-1:0] rem_in,
   input  wire logic [hons_pkg::CNT_W-1:0] count,
   output logic      [hons_pkg::KEY_W-1:0] dvd_out,
   output logic      [hons_pkg::CNT_W-1:0] rem_out
);
   import hons_pkg::*;

   logic [KEY_W-1:0] dvd_ff;
   logic [CNT_W-1:0] rem_ff, rem_in_c;

   always_comb begin
      logic [CNT_W:0]   t;
      logic [CNT_W-1:0] r;
      r = rem_in;
      t = '0;
      for (int i = 0; i < DIGIT_BITS; i++) begin
         t = {r, dvd_in[KEY_W-1-i]};
         if (t >= {1'b0, count}) begin
            t = t - {1'b0, count};
         end
         r = t[CNT_W-1:0];
      end
      rem_in_c = r;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dvd_ff <= dvd_in << DIGIT_BITS;
         rem_ff <= rem_in_c;
      end
   end

   assign dvd_out = dvd_ff;
   assign rem_out = rem_ff;
endmodule
`default_nettype wire

[design/hashed_owner_node_select.sv]
// Top level: config registers, finalizer hashes, pipelined modulo and fallback select.
// Pipeline: 15 register stages from request transaction to result valid (5 hash,
// 1 xor, 8 modulo, 1 out; the accepting edge loads the first).
// Throughput: one transaction per cycle; the whole pipeline holds only while the
// result register is full and not taken.
// Reset: synchronous, clears stage valid bits and loads node count 1, both enables 0.
// Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
module hashed_owner_node_select #(
   parameter int unsigned MAX_NODES = hons_pkg::MAX_NODES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [hons_pkg::KEY_W-1:0]  req_device_id,
   input  wire logic [hons_pkg::KEY_W-1:0]  req_inode_number,
   input  wire logic signed [hons_pkg::DESC_W-1:0] req_descriptor,
   input  wire logic [hons_pkg::IDX_W-1:0]  req_fallback_index,
   input  wire logic                        req_metadata_ok,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic      [hons_pkg::IDX_W-1:0]  rsp_owner_index,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [hons_pkg::ADDR_W-1:0] paddr,
   input  wire logic [hons_pkg::DATA_W-1:0] pwdata,
   output logic      [hons_pkg::DATA_W-1:0] prdata,
   output logic                             pready
);
   import hons_pkg::*;

   localparam int unsigned STAGES  = MIX_STAGES + 1 + DIV_STAGES + 1;
   localparam int unsigned S_HASH  = MIX_STAGES;
   localparam int unsigned S_LAST  = STAGES - 1;
   localparam logic [CNT_W-1:0] CNT_CLAMP =
      (MAX_NODES > 511) ? 9'h1FF : CNT_W'(MAX_NODES);

   // Configuration registers
   logic [CNT_W-1:0] cnt_ff;
   logic             rings_ff, multi_ff;
   logic             wr_en;
   logic [CNT_W-1:0] cnt_eff;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= NODE_COUNT_RST;
         rings_ff <= 1'b0;
         multi_ff <= 1'b0;
      end else if (wr_en) begin
         unique case (paddr[3:2])
            REG_NODE_COUNT: cnt_ff   <= pwdata[CNT_W-1:0];
            REG_RINGS_EN:   rings_ff <= pwdata[0];
            REG_MULTI_EN:   multi_ff <= pwdata[0];
            default: begin
               // drop writes to unmapped addresses
            end
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_NODE_COUNT: prdata = {{(DATA_W-CNT_W){1'b0}}, cnt_ff};
         REG_RINGS_EN:   prdata = {{(DATA_W-1){1'b0}}, rings_ff};
         REG_MULTI_EN:   prdata = {{(DATA_W-1){1'b0}}, multi_ff};
         default:        prdata = '0;
      endcase
   end

   // Clamp the modulus to the supported node count
   assign cnt_eff = (cnt_ff > CNT_CLAMP) ? CNT_CLAMP : cnt_ff;

   // Global advance: every stage moves unless the result register is blocked
   logic advance;
   logic [STAGES-1:0] vld_ff;
   side_type          side_ff [STAGES];
   side_type          side_in;

   assign advance   = !vld_ff[S_LAST] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[S_LAST];

   // Fallback set at entry; config stable while transactions in flight is user's duty
   always_comb begin
      side_in.fb = req_fallback_index;
      if (({1'b0, req_fallback_index} >= cnt_eff) && (cnt_eff != '0)) begin
         side_in.fb = '0;
      end
      side_in.take_fb = !rings_ff || !multi_ff || (cnt_eff <= 9'd1) ||
                        req_descriptor[DESC_W-1] || !req_metadata_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < STAGES; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Three finalizer lanes
   logic [KEY_W-1:0] h_dev, h_ino, h_desc;

   hons_mix u_mix_dev (
      .clock (clock), .en (advance), .value (req_device_id), .hash (h_dev)
   );
   hons_mix u_mix_ino (
      .clock (clock), .en (advance), .value (req_inode_number), .hash (h_ino)
   );
   hons_mix u_mix_desc (
      .clock (clock), .en (advance),
      .value ({{(KEY_W-DESC_W){1'b0}}, req_descriptor}), .hash (h_desc)
   );

   // Fold the lanes
   logic [KEY_W-1:0] hash_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         hash_ff <= h_dev ^ h_ino ^ h_desc;
      end
   end

   // Remainder by the node count, one byte of the hash per stage
   logic [KEY_W-1:0] dvd_w [DIV_STAGES+1];
   logic [CNT_W-1:0] rem_w [DIV_STAGES+1];

   assign dvd_w[0] = hash_ff;
   assign rem_w[0] = '0;

   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      hons_div_step u_step (
         .clock   (clock),
         .en      (advance),
         .dvd_in  (dvd_w[g]),
         .rem_in  (rem_w[g]),
         .count   (cnt_eff),
         .dvd_out (dvd_w[g+1]),
         .rem_out (rem_w[g+1])
      );
   end

   // Result register: pick the fallback or the hashed owner
   logic [IDX_W-1:0] owner_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         owner_ff <= side_ff[S_LAST-1].take_fb ? side_ff[S_LAST-1].fb
                                               : rem_w[DIV_STAGES][IDX_W-1:0];
      end
   end

   assign rsp_owner_index = owner_ff;

`ifndef SYNTH
   // Stall only when the result register is blocked
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("pipeline stalled without backpressure");

   // A hashed owner always falls below the node count
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !side_ff[S_LAST].take_fb) |-> ({1'b0, rsp_owner_index} < cnt_eff))
      else $error("hashed owner out of range");

   // A valid bit at the hash stage moves on into the modulo pipeline on an advance
   assert property (@(posedge clock) disable iff (reset)
      (advance && vld_ff[S_HASH]) |=> vld_ff[S_HASH+1])
      else $error("valid bit lost in modulo pipeline");

   // Nothing comes out right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");
`endif

endmodule
`default_nettype wire

[test/testbench.sv]
// Testbench for hashed_owner_node_select: owner index prediction and checking.
`timescale 1ns / 1ps
`default_nettype none

// Owner index predictor and queue of expected owner indexes.
class owner_scoreboard;
   logic [8:0] node_count = 9'd1;
   bit         rings_en = 1'b0;
   bit         multi_en = 1'b0;
   logic [7:0] pending_owners[$];
   int         mismatch_count = 0;

   function logic [63:0] finalize(input logic [63:0] v);
      logic [63:0] x;
      x = v ^ (v >> 30);
      x = x * 64'hbf58476d1ce4e5b9;
      x = x ^ (x >> 27);
      x = x * 64'h94d049bb133111eb;
      x = x ^ (x >> 31);
      return x;
   endfunction

   function void note_request(input logic [63:0] dev, input logic [63:0] ino,
                              input logic [31:0] desc, input logic [7:0] fb,
                              input bit meta);
      logic [63:0] modulus;
      logic [63:0] fallback;
      logic [63:0] mixed;
      modulus = (node_count > 9'd256) ? 64'd256 : 64'(node_count);
      fallback = 64'(fb);
      if (fallback >= modulus && modulus > 0) fallback = 0;
      if (!rings_en || !multi_en || modulus <= 1 || desc[31] || !meta) begin
         pending_owners.push_back(fallback[7:0]);
      end else begin
         mixed = finalize(dev) ^ finalize(ino) ^ finalize({32'd0, desc});
         pending_owners.push_back(8'(mixed % modulus));
      end
   endfunction

   function void check_owner(input logic [7:0] got);
      logic [7:0] want;
      if (pending_owners.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected owner transaction: got %0d", got);
         return;
      end
      want = pending_owners.pop_front();
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("owner_index mismatch: expected %0d got %0d", want, got);
      end
   endfunction
endclass

module testbench;
   import hons_pkg::*;

   localparam int unsigned RANDOM_REQUESTS = 950;
   localparam int unsigned PIPE_DEPTH = 15;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [KEY_W-1:0]  req_device_id = '0;
   logic [KEY_W-1:0]  req_inode_number = '0;
   logic [DESC_W-1:0] req_descriptor = '0;
   logic [IDX_W-1:0]  req_fallback_index = '0;
   logic              req_metadata_ok = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [IDX_W-1:0]  rsp_owner_index;
   logic              psel = 1'b0;
   logic              penable = 1'b0;
   logic              pwrite = 1'b0;
   logic [ADDR_W-1:0] paddr = '0;
   logic [DATA_W-1:0] pwdata = '0;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Quiet stretch: no idling on either side while set.
   bit                steady = 1'b0;

   owner_scoreboard   owners = new();

   hashed_owner_node_select uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_device_id(req_device_id), .req_inode_number(req_inode_number),
      .req_descriptor(req_descriptor), .req_fallback_index(req_fallback_index),
      .req_metadata_ok(req_metadata_ok),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_owner_index(rsp_owner_index),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Result side: stall about 6 percent of the time unless steady, check every transaction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) owners.check_owner(rsp_owner_index);
      rsp_ready <= reset ? 1'b0 : (steady || $urandom_range(99) >= 6);
   end

   // Write one register: setup cycle then access cycle.
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= ADDR_W'({index, 2'b00}); pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      // Mirror the write in the predictor with the register widths.
      case (index)
         REG_NODE_COUNT: owners.node_count = value[8:0];
         REG_RINGS_EN:   owners.rings_en = value[0];
         REG_MULTI_EN:   owners.multi_en = value[0];
         default: ;
      endcase
   endtask

   // Present one request and hold it until the transaction completes.
   task automatic send_request(input logic [63:0] dev, input logic [63:0] ino,
                               input logic [31:0] desc, input logic [7:0] fb,
                               input bit meta);
      while (!steady && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_device_id <= dev; req_inode_number <= ino;
      req_descriptor <= desc; req_fallback_index <= fb; req_metadata_ok <= meta;
      do @(posedge clock); while (!req_ready);
      owners.note_request(dev, ino, desc, fb, meta);
   endtask

   // Drop valid and wait until every expected owner has come back.
   task automatic drain;
      req_valid <= 1'b0;
      while (owners.pending_owners.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64;
      return {$urandom, $urandom};
   endfunction

   // Mostly hashing requests: valid descriptor and metadata, with some noise.
   task automatic random_requests(input int n);
      logic [31:0] desc;
      for (int k = 0; k < n; k++) begin
         desc = $urandom;
         if ($urandom_range(9) < 8) desc[31] = 1'b0;
         send_request(rand64(), rand64(), desc, 8'($urandom),
                      $urandom_range(9) != 0);
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset settings: fallback forced, count 1 corrects fallback to 0.
      send_request('0, '0, 32'd0, 8'd0, 1'b1);
      send_request('1, '1, 32'h7fffffff, 8'd255, 1'b1);
      drain();

      // Hashing on with the full node count; cover field extremes.
      write_reg(REG_NODE_COUNT, 32'd256);
      write_reg(REG_RINGS_EN, 32'd1);
      write_reg(REG_MULTI_EN, 32'd1);
      send_request('0, '0, 32'd0, 8'd0, 1'b1);
      send_request('1, '1, 32'h7fffffff, 8'd255, 1'b1);
      send_request('1, '0, 32'h80000000, 8'd200, 1'b1);   // negative descriptor
      send_request('1, '1, 32'hffffffff, 8'd7, 1'b1);     // descriptor -1
      send_request(64'h8000000000000001, 64'h1, 32'd3, 8'd9, 1'b0); // no metadata
      send_request(64'h0123456789abcdef, 64'hfedcba9876543210, 32'd42, 8'd1, 1'b1);
      drain();

      // Count above range saturates; count 0 keeps the fallback as is.
      write_reg(REG_NODE_COUNT, 32'h1ff);
      send_request(rand64(), rand64(), 32'd5, 8'd255, 1'b1);
      send_request(rand64(), rand64(), 32'hfffffff0, 8'd255, 1'b1);
      drain();
      write_reg(REG_NODE_COUNT, 32'd0);
      send_request(rand64(), rand64(), 32'd5, 8'd255, 1'b1);
      send_request(rand64(), rand64(), 32'd5, 8'd0, 1'b1);
      drain();
      write_reg(REG_NODE_COUNT, 32'd2);
      send_request(rand64(), rand64(), 32'd5, 8'd1, 1'b1);
      send_request(rand64(), rand64(), 32'd5, 8'd2, 1'b1);
      drain();

      // One enable off at a time forces the fallback.
      write_reg(REG_RINGS_EN, 32'd0);
      send_request(rand64(), rand64(), 32'd5, 8'd1, 1'b1);
      drain();
      write_reg(REG_RINGS_EN, 32'd1);
      write_reg(REG_MULTI_EN, 32'd0);
      send_request(rand64(), rand64(), 32'd5, 8'd1, 1'b1);
      drain();
      write_reg(REG_MULTI_EN, 32'd1);

      // Random phases over several counts; one phase without any idling.
      write_reg(REG_NODE_COUNT, 32'd7);
      random_requests(300);
      drain();
      write_reg(REG_NODE_COUNT, 32'd256);
      steady = 1'b1;
      random_requests(200);
      drain();
      steady = 1'b0;
      write_reg(REG_NODE_COUNT, 32'd1 + $urandom_range(300));
      random_requests(200);
      drain();
      write_reg(REG_NODE_COUNT, 32'd3);
      write_reg(REG_MULTI_EN, 32'($urandom_range(1)));
      random_requests(RANDOM_REQUESTS - 700);
      drain();

      if (owners.mismatch_count == 0 && owners.pending_owners.size() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #5ms;
      $display("testbench failed");
      $finish;
   end
endmodule
`default_nettype wire
